// ----- rtl/tts_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tts_pkg
// Shared constants for the time-triggered task scheduler.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int MAX_TASKS_DEF = 16;
  localparam int KIND_W        = 2;
  localparam int TIDX_W        = 4;
  localparam int TIME_W        = 32;

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_ADD_OK   = 2'd0;
  localparam kind_t KIND_ADD_FULL = 2'd1;
  localparam kind_t KIND_READY    = 2'd2;
  localparam kind_t KIND_NONE     = 2'd3;

endpackage
`default_nettype wire

// ----- rtl/tts_table.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tts_table
// Period and countdown memories: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tts_table
  import tts_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF,
  parameter int IW        = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
  input  wire               clk,
  input  wire               we_per,
  input  wire               we_cnt,
  input  wire  [IW-1:0]     waddr,
  input  wire  [TIME_W-1:0] wper,
  input  wire  [TIME_W-1:0] wcnt,
  input  wire               re,
  input  wire  [IW-1:0]     raddr,
  output logic [TIME_W-1:0] rper,
  output logic [TIME_W-1:0] rcnt
);

  logic [TIME_W-1:0] per_mem [MAX_TASKS];
  logic [TIME_W-1:0] cnt_mem [MAX_TASKS];

  always_ff @(posedge clk) begin
    if (we_per) begin
      per_mem[waddr] <= wper;
    end
    if (re) begin
      rper <= per_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (we_cnt) begin
      cnt_mem[waddr] <= wcnt;
    end
    if (re) begin
      rcnt <= cnt_mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/time_triggered_task_scheduler.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// time_triggered_task_scheduler
// Cooperative task table: add beats append tasks while room remains, tick
// beats report ready tasks in index order.
// ----------------------------------------------------------------------------
// An add beat gives one result in the cycle after it is taken. A tick beat
// walks the used entries one per cycle while the result side does not stall,
// through the table memories (read, decrement or reload, write back). Each
// ready task gives one result beat; the final one carries last, and a tick
// with no ready task gives a single none result with last. Only one beat is
// in work at a time.
module time_triggered_task_scheduler
  import tts_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire               in_mode,
  input  wire  [TIME_W-1:0] in_task_period,
  input  wire  [TIME_W-1:0] in_start_offset,
  output logic              out_valid,
  input  wire               out_stall,
  output logic [KIND_W-1:0] out_kind,
  output logic [TIDX_W-1:0] out_task_index,
  output logic              out_last
);

  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EVAL  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic [IW-1:0]     pend_idx_r, pend_idx_nxt;
  logic              out_v_r, out_v_nxt;
  kind_t             kind_r, kind_nxt;
  logic [TIDX_W-1:0] tidx_r, tidx_nxt;
  logic              last_r, last_nxt;

  logic              we_per, we_cnt, re;
  logic [IW-1:0]     waddr, raddr;
  logic [TIME_W-1:0] wcnt, rper, rcnt;

  logic              in_acc, out_free, hit, need_push, adv, at_end;
  logic [31:0]       idx_ext, pend_ext, cnt_ext;

  tts_table #(
    .MAX_TASKS (MAX_TASKS),
    .IW        (IW)
  ) u_table (
    .clk    (clk),
    .we_per (we_per),
    .we_cnt (we_cnt),
    .waddr  (waddr),
    .wper   (in_task_period),
    .wcnt   (wcnt),
    .re     (re),
    .raddr  (raddr),
    .rper   (rper),
    .rcnt   (rcnt)
  );

  assign in_stall       = (state_r != S_IDLE) || (out_v_r && out_stall);
  assign in_acc         = in_valid && !in_stall;
  assign out_free       = !out_v_r || !out_stall;
  assign hit            = (rcnt <= TIME_W'(1));
  assign need_push      = hit && pend_v_r;
  assign adv            = !need_push || out_free;
  assign at_end         = (idx_r == IW'(count_r - CW'(1)));
  assign idx_ext        = 32'(idx_r);
  assign pend_ext       = 32'(pend_idx_r);
  assign cnt_ext        = 32'(count_r);

  assign out_valid      = out_v_r;
  assign out_kind       = kind_r;
  assign out_task_index = tidx_r;
  assign out_last       = last_r;

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    pend_v_nxt   = pend_v_r;
    pend_idx_nxt = pend_idx_r;
    out_v_nxt    = out_v_r && out_stall;
    kind_nxt     = kind_r;
    tidx_nxt     = tidx_r;
    last_nxt     = last_r;
    we_per       = 1'b0;
    we_cnt       = 1'b0;
    waddr        = idx_r;
    wcnt         = in_start_offset;
    re           = 1'b0;
    raddr        = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (!in_mode) begin
            out_v_nxt = 1'b1;
            last_nxt  = 1'b1;
            if (count_r < CW'(MAX_TASKS)) begin
              we_per    = 1'b1;
              we_cnt    = 1'b1;
              waddr     = IW'(count_r);
              count_nxt = count_r + CW'(1);
              kind_nxt  = KIND_ADD_OK;
              tidx_nxt  = cnt_ext[TIDX_W-1:0];
            end else begin
              kind_nxt  = KIND_ADD_FULL;
              tidx_nxt  = '0;
            end
          end else begin
            pend_v_nxt = 1'b0;
            idx_nxt    = '0;
            if (count_r == '0) begin
              state_nxt = S_FLUSH;
            end else begin
              re        = 1'b1;
              state_nxt = S_EVAL;
            end
          end
        end
      end
      S_EVAL: begin
        if (adv) begin
          we_cnt = 1'b1;
          wcnt   = hit ? (rper - TIME_W'(1)) : (rcnt - TIME_W'(1));
          if (need_push) begin
            out_v_nxt = 1'b1;
            kind_nxt  = KIND_READY;
            tidx_nxt  = pend_ext[TIDX_W-1:0];
            last_nxt  = 1'b0;
          end
          if (hit) begin
            pend_v_nxt   = 1'b1;
            pend_idx_nxt = idx_r;
          end
          if (at_end) begin
            state_nxt = S_FLUSH;
          end else begin
            re      = 1'b1;
            raddr   = idx_r + IW'(1);
            idx_nxt = idx_r + IW'(1);
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          out_v_nxt = 1'b1;
          last_nxt  = 1'b1;
          if (pend_v_r) begin
            kind_nxt = KIND_READY;
            tidx_nxt = pend_ext[TIDX_W-1:0];
          end else begin
            kind_nxt = KIND_NONE;
            tidx_nxt = '0;
          end
          pend_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (idx_ext[31]) begin
      idx_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    kind_r     <= kind_nxt;
    tidx_r     <= tidx_nxt;
    last_r     <= last_nxt;
  end

endmodule
`default_nettype wire

// ----- rtl/tts_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tts_checker
// Port-level checks on the scheduler's result sequencing.
// ----------------------------------------------------------------------------
module tts_checker
  import tts_pkg::*;
(
  input wire              clk,
  input wire              rst_n,
  input wire              in_valid,
  input wire              in_stall,
  input wire              in_mode,
  input wire              out_valid,
  input wire              out_stall,
  input wire [KIND_W-1:0] out_kind,
  input wire [TIDX_W-1:0] out_task_index,
  input wire              out_last
);

  // add beat answers in the next cycle with a single closing result
  a_add_resp : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !in_mode) |=>
      (out_valid && out_last && (out_kind == KIND_ADD_OK || out_kind == KIND_ADD_FULL)))
    else $error("add beat not answered");

  // tick walk blocks the input side
  a_tick_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_mode) |=> in_stall)
    else $error("input taken during tick walk");

  a_single_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == KIND_ADD_OK || out_kind == KIND_ADD_FULL ||
                   out_kind == KIND_NONE)) |-> out_last)
    else $error("single result without last");

  a_zero_index : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == KIND_ADD_FULL || out_kind == KIND_NONE)) |->
      (out_task_index == '0))
    else $error("nonzero index on full or none result");

  a_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_kind) &&
      $stable(out_task_index) && $stable(out_last)))
    else $error("stalled result changed");

endmodule

bind time_triggered_task_scheduler tts_checker u_tts_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_mode        (in_mode),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_kind       (out_kind),
  .out_task_index (out_task_index),
  .out_last       (out_last)
);
`default_nettype wire
